/* rtl/tce_pkg.sv */
package tce_pkg;

    localparam int COLUMNS  = 80;
    localparam int MAX_ROWS = 50;
    localparam int CELLS    = COLUMNS * MAX_ROWS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int FROW_W   = $clog2(MAX_ROWS);
    localparam int ROW_W    = 6;
    localparam int COL_W    = 7;
    localparam int CELL_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] BLANK_CODE   = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'd31;

    localparam logic [ROW_W-1:0] ROWS_SMALL = 6'd25;
    localparam logic [ROW_W-1:0] ROWS_LARGE = 6'd50;
    localparam logic SMALL_OK = (25 <= MAX_ROWS);
    localparam logic LARGE_OK = (50 <= MAX_ROWS);

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_BACK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP  = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_column;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
        logic              cursor_moved;
        logic [CELL_W-1:0] cell_value;
    } t_out_item;

    typedef struct packed {
        logic [7:0]       text_color;
        logic [ROW_W-1:0] rows_in_use;
        logic             wrap_mode;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_scr_req;

    typedef struct packed {
        logic              we;
        logic [FROW_W-1:0] waddr;
        logic [COL_W-1:0]  wdata;
        logic              re;
        logic [FROW_W-1:0] raddr;
    } t_fill_req;

    typedef struct packed {
        logic             vld;
        logic [COL_W-1:0] data;
    } t_fill_rd;

endpackage

/* rtl/text_console_engine.sv */
// Text console: 80-column screen store of 16-bit cells (colour high byte,
// character low byte) with a cursor and a per-row fill column.
// Input channel (i_in_valid / o_in_stall, i_in_item): one operation per
// transfer: put char, backspace, clear screen, read cell. Output channel
// (o_out_valid / i_out_stall, o_out_item): exactly one result per item, in
// order. Config channel (i_cfg_valid / o_cfg_ready): register index and data;
// ready is always high. Write config only while no item is in flight.
// Put char without scroll, backspace inside a row and an out-of-range read
// finish directly; a cell read and backspace at column 0 first read the
// screen or fill memory; a put char that scrolls walks rows_in_use rows of
// 80 cells, and clear blanks every cell. The screen memory has a single
// write port and writes one cell per cycle during scroll and blanking walks.
// Each item is finished before the next is accepted.
// Reset: the store's 4000 cells are blanked, one cell a cycle, with input
// stalled; an accepted rows_in_use write starts the same pass.
// When the receiver stalls, two results queue; the input then stalls.
module text_console_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tce_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tce_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tce_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [7:0]                          i_cfg_data
);

    tce_pkg::t_cfg       r_cfg, n_cfg;
    logic                blank_req;
    logic                cfg_wr;
    logic                rows_ok;

    tce_pkg::t_out_item  r_q0, n_q0, r_q1, n_q1;
    logic                r_v0, n_v0, r_v1, n_v1;
    logic                pop;
    logic                res_push;
    tce_pkg::t_out_item  res;

    tce_pkg::t_scr_req   scr_req;
    logic [tce_pkg::CELL_W-1:0] scr_rdata;
    tce_pkg::t_fill_req  fill_req;
    tce_pkg::t_fill_rd   fill_rd;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign rows_ok     = (tce_pkg::SMALL_OK && i_cfg_data[5:0] == tce_pkg::ROWS_SMALL) ||
                         (tce_pkg::LARGE_OK && i_cfg_data[5:0] == tce_pkg::ROWS_LARGE);

    always_comb begin
        n_cfg     = r_cfg;
        blank_req = 1'b0;
        if (cfg_wr) begin
            unique case (i_cfg_index)
                tce_pkg::CFG_COLOR: begin
                    n_cfg.text_color = i_cfg_data;
                end
                tce_pkg::CFG_ROWS: begin
                    if (rows_ok) begin
                        n_cfg.rows_in_use = i_cfg_data[5:0];
                        blank_req         = 1'b1;
                    end
                end
                tce_pkg::CFG_WRAP: begin
                    n_cfg.wrap_mode = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_color  <= tce_pkg::RESET_COLOR;
            r_cfg.rows_in_use <= tce_pkg::ROWS_SMALL;
            r_cfg.wrap_mode   <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    tce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_blank_req (blank_req),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_res_room  (!r_v1),
        .o_res_push  (res_push),
        .o_res       (res),
        .o_scr_req   (scr_req),
        .i_scr_rdata (scr_rdata),
        .o_fill_req  (fill_req),
        .i_fill_rd   (fill_rd)
    );

    tce_screen_ram u_screen (
        .i_clk   (i_clk),
        .i_req   (scr_req),
        .o_rdata (scr_rdata)
    );

    tce_fill_ram u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fill_req),
        .o_rd    (fill_rd)
    );

    // two-entry result queue: head drives the port, second holds a skid
    assign pop = r_v0 && !i_out_stall;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (pop) begin
            if (r_v1) begin
                n_q0 = r_q1;
                n_v1 = res_push;
                n_q1 = res;
            end else begin
                n_v0 = res_push;
                n_q0 = res;
            end
        end else if (res_push) begin
            if (r_v0) begin
                n_v1 = 1'b1;
                n_q1 = res;
            end else begin
                n_v0 = 1'b1;
                n_q0 = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_out_valid = r_v0;
    assign o_out_item  = r_q0;

endmodule

/* rtl/tce_screen_ram.sv */
module tce_screen_ram (
    input  logic                              i_clk,
    input  tce_pkg::t_scr_req                 i_req,
    output logic [tce_pkg::CELL_W-1:0]        o_rdata
);

    logic [tce_pkg::CELL_W-1:0] r_mem [tce_pkg::CELLS];
    logic [tce_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tce_fill_ram.sv */
module tce_fill_ram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tce_pkg::t_fill_req i_req,
    output tce_pkg::t_fill_rd  o_rd
);

    logic [tce_pkg::COL_W-1:0]    r_mem [tce_pkg::MAX_ROWS];
    logic [tce_pkg::MAX_ROWS-1:0] r_vld;
    logic [tce_pkg::COL_W-1:0]    r_rd_data;
    logic                         r_rd_vld;

    // a row never written reads as zero fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_vld[i_req.waddr] <= 1'b1;
            end
            if (i_req.re) begin
                r_rd_vld <= r_vld[i_req.raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= r_mem[i_req.raddr];
        end
    end

    assign o_rd.vld  = r_rd_vld;
    assign o_rd.data = r_rd_data;

endmodule

/* rtl/tce_ctrl.sv */
module tce_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tce_pkg::t_cfg              i_cfg,
    input  logic                       i_blank_req,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tce_pkg::t_in_item          i_in_item,
    input  logic                       i_res_room,
    output logic                       o_res_push,
    output tce_pkg::t_out_item         o_res,
    output tce_pkg::t_scr_req          o_scr_req,
    input  logic [tce_pkg::CELL_W-1:0] i_scr_rdata,
    output tce_pkg::t_fill_req         o_fill_req,
    input  tce_pkg::t_fill_rd          i_fill_rd
);

    localparam logic [2:0] S_SWEEP  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_BACK   = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_SCROLL = 3'd5;
    localparam logic [2:0] S_DRAIN  = 3'd6;

    function automatic logic [tce_pkg::ADDR_W-1:0] cell_addr(
        input logic [tce_pkg::ROW_W-1:0] row,
        input logic [tce_pkg::COL_W-1:0] col
    );
        return tce_pkg::ADDR_W'(int'(row) * tce_pkg::COLUMNS + int'(col));
    endfunction

    logic [2:0]                  r_state, n_state;
    tce_pkg::t_in_item           r_item, n_item;
    logic [tce_pkg::ROW_W-1:0]   r_cur_row, n_cur_row;
    logic [tce_pkg::COL_W-1:0]   r_cur_col, n_cur_col;
    logic [tce_pkg::ADDR_W-1:0]  r_saddr, n_saddr;
    logic [tce_pkg::ROW_W-1:0]   r_srow, n_srow;
    logic [tce_pkg::COL_W-1:0]   r_scol, n_scol;
    logic [7:0]                  r_color, n_color;
    logic                        r_reply, n_reply;
    logic                        r_wb_vld, n_wb_vld;
    logic [tce_pkg::ADDR_W-1:0]  r_wb_addr, n_wb_addr;
    logic                        r_wb_copy, n_wb_copy;
    logic                        r_wb_fill, n_wb_fill;
    logic [tce_pkg::FROW_W-1:0]  r_wb_frow, n_wb_frow;

    logic [tce_pkg::ROW_W-1:0]   h_last;
    logic [tce_pkg::ROW_W-1:0]   row_inc;
    logic [tce_pkg::COL_W-1:0]   fill_col;
    logic                        is_nl;
    logic                        copy;
    logic                        accept;

    assign o_in_stall = !(r_state == S_IDLE && i_res_room);
    assign accept     = i_in_valid && !o_in_stall;
    assign h_last     = i_cfg.rows_in_use - 6'd1;
    assign row_inc    = r_cur_row + 6'd1;
    assign is_nl      = (r_item.char_code == tce_pkg::NEWLINE_CODE);
    assign copy       = (r_srow != h_last);

    always_comb begin
        fill_col = i_fill_rd.vld ? i_fill_rd.data : '0;
        if (int'(fill_col) >= tce_pkg::COLUMNS) begin
            fill_col = tce_pkg::COL_LAST;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        n_saddr   = r_saddr;
        n_srow    = r_srow;
        n_scol    = r_scol;
        n_color   = r_color;
        n_reply   = r_reply;
        n_wb_vld  = 1'b0;
        n_wb_addr = r_wb_addr;
        n_wb_copy = r_wb_copy;
        n_wb_fill = r_wb_fill;
        n_wb_frow = r_wb_frow;
        o_res_push = 1'b0;
        o_res      = '0;
        o_scr_req  = '0;
        o_fill_req = '0;

        // write back the row moved up during a scroll, or blank the last row
        if (r_wb_vld) begin
            o_scr_req.we    = 1'b1;
            o_scr_req.waddr = r_wb_addr;
            o_scr_req.wdata = r_wb_copy ? i_scr_rdata
                                        : {i_cfg.text_color, tce_pkg::BLANK_CODE};
            if (r_wb_fill) begin
                o_fill_req.we    = 1'b1;
                o_fill_req.waddr = r_wb_frow;
                o_fill_req.wdata = i_fill_rd.vld ? i_fill_rd.data : '0;
            end
        end

        unique case (r_state)
            S_SWEEP: begin
                o_scr_req.we    = 1'b1;
                o_scr_req.waddr = r_saddr;
                o_scr_req.wdata = {r_color, tce_pkg::BLANK_CODE};
                if (r_saddr == tce_pkg::CELL_LAST) begin
                    n_state = S_IDLE;
                    if (r_reply) begin
                        o_res_push = 1'b1;
                        o_res.cursor_row    = r_cur_row;
                        o_res.cursor_column = r_cur_col;
                        o_res.cursor_moved  = 1'b1;
                    end
                end else begin
                    n_saddr = r_saddr + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_item  = i_in_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_item.operation)
                    tce_pkg::OP_PUT: begin
                        if (!is_nl) begin
                            o_scr_req.we    = 1'b1;
                            o_scr_req.waddr = cell_addr(r_cur_row, r_cur_col);
                            o_scr_req.wdata = {i_cfg.text_color, r_item.char_code};
                        end
                        n_state = S_IDLE;
                        if (is_nl || r_cur_col == tce_pkg::COL_LAST) begin
                            o_fill_req.we    = 1'b1;
                            o_fill_req.waddr = tce_pkg::FROW_W'(r_cur_row);
                            o_fill_req.wdata = r_cur_col;
                            n_cur_col = '0;
                            if (row_inc >= i_cfg.rows_in_use) begin
                                if (i_cfg.wrap_mode) begin
                                    n_cur_row = '0;
                                end else begin
                                    n_cur_row = h_last;
                                    n_state   = S_SCROLL;
                                    n_srow    = '0;
                                    n_scol    = '0;
                                    n_saddr   = '0;
                                end
                            end else begin
                                n_cur_row = row_inc;
                            end
                        end else begin
                            n_cur_col = r_cur_col + 1'b1;
                        end
                        if (n_state == S_IDLE) begin
                            o_res_push = 1'b1;
                            o_res.cursor_row    = n_cur_row;
                            o_res.cursor_column = n_cur_col;
                            o_res.cursor_moved  = !i_cfg.wrap_mode;
                        end
                    end
                    tce_pkg::OP_BACK: begin
                        if (r_cur_col != '0) begin
                            n_cur_col       = r_cur_col - 1'b1;
                            o_scr_req.we    = 1'b1;
                            o_scr_req.waddr = cell_addr(r_cur_row, n_cur_col);
                            o_scr_req.wdata = {i_cfg.text_color, tce_pkg::BLANK_CODE};
                            o_res_push = 1'b1;
                            o_res.cursor_row    = r_cur_row;
                            o_res.cursor_column = n_cur_col;
                            o_res.cursor_moved  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_cur_row = (r_cur_row != '0) ? r_cur_row - 1'b1 : r_cur_row;
                            o_fill_req.re    = 1'b1;
                            o_fill_req.raddr = tce_pkg::FROW_W'(n_cur_row);
                            n_state = S_BACK;
                        end
                    end
                    tce_pkg::OP_CLEAR: begin
                        n_cur_row = '0;
                        n_cur_col = '0;
                        n_color   = i_cfg.text_color;
                        n_saddr   = '0;
                        n_reply   = 1'b1;
                        n_state   = S_SWEEP;
                    end
                    tce_pkg::OP_READ: begin
                        if (int'(r_item.read_row) < tce_pkg::MAX_ROWS &&
                            int'(r_item.read_column) < tce_pkg::COLUMNS) begin
                            o_scr_req.re    = 1'b1;
                            o_scr_req.raddr = cell_addr(r_item.read_row, r_item.read_column);
                            n_state = S_READ;
                        end else begin
                            o_res_push = 1'b1;
                            o_res.cursor_row    = r_cur_row;
                            o_res.cursor_column = r_cur_col;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_BACK: begin
                n_cur_col       = fill_col;
                o_scr_req.we    = 1'b1;
                o_scr_req.waddr = cell_addr(r_cur_row, fill_col);
                o_scr_req.wdata = {i_cfg.text_color, tce_pkg::BLANK_CODE};
                o_res_push = 1'b1;
                o_res.cursor_row    = r_cur_row;
                o_res.cursor_column = fill_col;
                o_res.cursor_moved  = 1'b1;
                n_state = S_IDLE;
            end
            S_READ: begin
                o_res_push = 1'b1;
                o_res.cursor_row    = r_cur_row;
                o_res.cursor_column = r_cur_col;
                o_res.cell_value    = i_scr_rdata;
                n_state = S_IDLE;
            end
            S_SCROLL: begin
                // fetch the cell one row below and write it back next cycle; the last row is written blank
                if (copy) begin
                    o_scr_req.re    = 1'b1;
                    o_scr_req.raddr = r_saddr + tce_pkg::ADDR_W'(tce_pkg::COLUMNS);
                    if (r_scol == '0) begin
                        o_fill_req.re    = 1'b1;
                        o_fill_req.raddr = tce_pkg::FROW_W'(r_srow + 1'b1);
                    end
                end
                n_wb_vld  = 1'b1;
                n_wb_addr = r_saddr;
                n_wb_copy = copy;
                n_wb_fill = copy && (r_scol == '0);
                n_wb_frow = tce_pkg::FROW_W'(r_srow);
                n_saddr   = r_saddr + 1'b1;
                if (r_scol == tce_pkg::COL_LAST) begin
                    n_scol = '0;
                    n_srow = r_srow + 1'b1;
                    if (!copy) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_scol = r_scol + 1'b1;
                end
            end
            S_DRAIN: begin
                o_res_push = 1'b1;
                o_res.cursor_row    = r_cur_row;
                o_res.cursor_column = r_cur_col;
                o_res.cursor_moved  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // height change: blank the whole store and home the cursor
        if (i_blank_req) begin
            n_state   = S_SWEEP;
            n_saddr   = '0;
            n_color   = i_cfg.text_color;
            n_reply   = 1'b0;
            n_cur_row = '0;
            n_cur_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_saddr   <= '0;
            r_srow    <= '0;
            r_scol    <= '0;
            r_color   <= tce_pkg::RESET_COLOR;
            r_reply   <= 1'b0;
            r_wb_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_saddr   <= n_saddr;
            r_srow    <= n_srow;
            r_scol    <= n_scol;
            r_color   <= n_color;
            r_reply   <= n_reply;
            r_wb_vld  <= n_wb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_wb_addr <= n_wb_addr;
        r_wb_copy <= n_wb_copy;
        r_wb_fill <= n_wb_fill;
        r_wb_frow <= n_wb_frow;
    end

endmodule

/* rtl/tce_checker.sv */
module tce_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input tce_pkg::t_out_item            o_out_item
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("result changed while stalled");

    // one item at a time: input stalls right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is in work");

    // only a cell read returns cell data, and a read never moves the cursor
    a_cell_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.cursor_moved |-> o_out_item.cell_value == '0)
        else $error("moved cursor reported with cell data");

endmodule

bind text_console_engine tce_checker u_tce_checker (.*);
